// ----- rtl/core/safeguarded_newton_root_finder_core_assert.svh -----
// Assertion macros for the safeguarded Newton root finder core.
// Included by the top level; no other dependencies.
`ifndef SAFEGUARDED_NEWTON_ROOT_FINDER_CORE_ASSERT_SVH
`define SAFEGUARDED_NEWTON_ROOT_FINDER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define SNRF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define SNRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define SNRF_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SNRF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/core/snrf_pkg.sv -----
// Types and constants of the safeguarded Newton root finder.
// No dependencies.
`default_nettype none
package snrf_pkg;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_FIRST  = 3'd1,
		PH_SECOND = 3'd2,
		PH_MID    = 3'd3,
		PH_ITER   = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		K_EVAL      = 3'd0,
		K_ROOT      = 3'd1,
		K_NOBRACKET = 3'd2,
		K_MAXITER   = 3'd3,
		K_IGNORED   = 3'd4
	} kind_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_A,
		S_MUL_B,
		S_MUL_C,
		S_DECIDE,
		S_BISECT,
		S_DIV,
		S_NEWT,
		S_FINISH,
		S_DONE
	} state_t;

	typedef struct packed {
		logic        div_start;
		logic [32:0] mul_a;
		logic [32:0] mul_b;
	} ctl_t;

	localparam logic [31:0] MAX32 = 32'h7FFF_FFFF;
	localparam logic [31:0] MIN32 = 32'h8000_0000;
	localparam logic        CMD_START = 1'b0;
	localparam logic        REG_ACCURACY = 1'b0;

	// Saturate a 33-bit signed value to 32 bits.
	function automatic logic [31:0] sat33(input logic signed [32:0] v);
		if (v > 33'sh0_7FFF_FFFF)
			return MAX32;
		else if (v < -33'sh0_8000_0000)
			return MIN32;
		else
			return v[31:0];
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/snrf_if.sv -----
// Request and response channels of the root finder.
// Depend on nothing but plain logic.
`default_nettype none
interface snrf_req_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [31:0] lower_bound;
	logic [31:0] upper_bound;
	logic [31:0] func_value;
	logic [31:0] func_slope;

	modport source (output valid, command, lower_bound, upper_bound, func_value, func_slope,
		input ready);
	modport sink (input valid, command, lower_bound, upper_bound, func_value, func_slope,
		output ready);
endinterface

interface snrf_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [31:0] point;

	modport source (output valid, kind, point, input ready);
	modport sink (input valid, kind, point, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/safeguarded_newton_root_finder_core.sv -----
// Safeguarded Newton root finder core in signed fixed point (top level).
// Depends on snrf_pkg, snrf_if.sv, snrf_div and the assertion macro header.
//
// Use: the request channel carries one beat per command. A start beat
// (command 0) brings the two bracket ends; every later beat (command 1)
// answers the last requested point with f and f' there. Each request beat
// gives exactly one response beat: a point to evaluate, the root, or a
// not-bracketed, too-many-iterations or ignored code.
// Flow: start beats and bracket replies go from the accepting edge to the
// done state, then into the output register once that register is free.
// A reply that drives an iteration runs three passes through one shared
// 33x33 multiplier and a decision state, then either a bisection step or
// the two-bit-per-cycle divider and a Newton step; both paths then pass
// through the finish and done states to the output register.
// The divider sets the rate: one item at a time, req.ready is high only
// while the sequencer is idle.
// Reset clears the sequencer, the search phase and the output register;
// accuracy returns to 1. The APB port writes accuracy at address 0.
// A stalled response holds in the output register; the sequencer waits with
// the finished result and a new beat is still taken once it has moved on.
`default_nettype none
module safeguarded_newton_root_finder_core #(
	parameter int ITER_LIMIT = 100,
	parameter int FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	snrf_req_if.sink         req,
	snrf_rsp_if.source       rsp,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import snrf_pkg::*;

	`include "safeguarded_newton_root_finder_core_assert.svh"

	state_t st_q, st_d;
	phase_t phase_q;
	ctl_t   ctl;

	logic [30:0] accuracy_q;
	logic signed [31:0] first_q, second_q, vfirst_q, neg_q, pos_q;
	logic signed [31:0] est_q, step_q, pstep_q, f_q, df_q;
	logic [6:0]  iter_q;
	logic signed [65:0] prod_q;
	logic        a_gt_q, a_lt_q, b_gt_q, b_lt_q, bis_q;
	kind_t       res_kind_q, out_kind_q;
	logic [31:0] res_point_q, out_point_q;
	logic        out_vld_q;

	logic        accept, out_free;
	logic signed [63:0] fs;
	logic [63:0] fs_mag;
	logic [31:0] df_mag, pstep_mag, step_mag;
	logic signed [65:0] fs_x;
	logic        div_done;
	logic [63:0] div_q;

	// bracket setup arithmetic
	logic signed [32:0] ends_sum, ends_diff, ends_mag;
	logic signed [31:0] f_in, fl;
	// iteration arithmetic
	logic        same_sign_ab, bisect;
	logic signed [32:0] bis_dx, cand;
	logic [31:0] est_new;
	logic        is_root;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_ACCURACY) ? {1'b0, accuracy_q} : '0;

	assign accept = req.valid && req.ready;
	assign req.ready = (st_q == S_IDLE);
	assign out_free = !out_vld_q || rsp.ready;

	assign rsp.valid = out_vld_q;
	assign rsp.kind = out_kind_q;
	assign rsp.point = out_point_q;

	assign f_in = req.func_value;
	assign fl = vfirst_q;
	assign fs = 64'(f_q) <<< FRAC_BITS;
	assign fs_mag = fs[63] ? 64'(-fs) : 64'(fs);
	assign fs_x = 66'(fs);
	assign df_mag = df_q[31] ? 32'(-df_q) : 32'(df_q);
	assign pstep_mag = pstep_q[31] ? 32'(-pstep_q) : 32'(pstep_q);
	assign step_mag = step_q[31] ? 32'(-step_q) : 32'(step_q);

	assign ends_sum = 33'(first_q) + 33'(second_q);
	assign ends_diff = 33'(second_q) - 33'(first_q);
	assign ends_mag = ends_diff[32] ? -ends_diff : ends_diff;

	// Guard: a*b >= 0 when either sign is zero or both signs agree.
	assign same_sign_ab = (!a_gt_q && !a_lt_q) || (!b_gt_q && !b_lt_q) ||
		(a_gt_q == b_gt_q);
	assign bisect = (df_q == '0) || same_sign_ab ||
		({fs_mag[62:0], 1'b0} > prod_q[63:0]);

	// Half of the bracket width rounds toward minus infinity.
	assign bis_dx = (33'(pos_q) - 33'(neg_q)) >>> 1;
	assign cand = bis_q ? (33'(neg_q) + 33'(step_q)) : (33'(est_q) - 33'(step_q));
	assign est_new = sat33(cand);
	assign is_root = bis_q ? (est_new == neg_q) : (est_new == est_q);

	snrf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.dividend (fs_mag),
		.divisor  (df_mag),
		.done     (div_done),
		.quotient (div_q)
	);

	// Next state of the sequencer.
	always_comb begin
		st_d = st_q;
		case (st_q)
			S_IDLE: begin
				if (accept) begin
					if (req.command == CMD_START)
						st_d = S_DONE;
					else if (phase_q == PH_MID ||
						(phase_q == PH_ITER && iter_q < 7'(ITER_LIMIT)))
						st_d = S_MUL_A;
					else
						st_d = S_DONE;
				end
			end
			S_MUL_A:  st_d = S_MUL_B;
			S_MUL_B:  st_d = S_MUL_C;
			S_MUL_C:  st_d = S_DECIDE;
			S_DECIDE: st_d = bisect ? S_BISECT : S_DIV;
			S_BISECT: st_d = S_FINISH;
			S_DIV:    st_d = div_done ? S_NEWT : S_DIV;
			S_NEWT:   st_d = S_FINISH;
			S_FINISH: st_d = S_DONE;
			S_DONE:   st_d = out_free ? S_IDLE : S_DONE;
			default:  st_d = S_IDLE;
		endcase
	end

	// Multiplier operands and divider launch.
	always_comb begin
		ctl.div_start = 1'b0;
		ctl.mul_a = '0;
		ctl.mul_b = 33'(df_q);
		case (st_q)
			S_MUL_A: ctl.mul_a = 33'(est_q) - 33'(pos_q);
			S_MUL_B: ctl.mul_a = 33'(est_q) - 33'(neg_q);
			S_MUL_C: begin
				ctl.mul_a = {1'b0, pstep_mag};
				ctl.mul_b = {1'b0, df_mag};
			end
			S_DECIDE: ctl.div_start = !bisect;
			default: ctl.mul_a = '0;
		endcase
	end

	// Shared multiplier: one product a cycle, registered.
	always_ff @(posedge clk) begin
		prod_q <= 66'($signed(ctl.mul_a)) * 66'($signed(ctl.mul_b));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			phase_q <= PH_IDLE;
			accuracy_q <= 31'd1;
			first_q <= '0;
			second_q <= '0;
			vfirst_q <= '0;
			neg_q <= '0;
			pos_q <= '0;
			est_q <= '0;
			step_q <= '0;
			pstep_q <= '0;
			iter_q <= '0;
			out_vld_q <= 1'b0;
			out_kind_q <= K_IGNORED;
			out_point_q <= '0;
			res_kind_q <= K_IGNORED;
			res_point_q <= '0;
			f_q <= '0;
			df_q <= '0;
			a_gt_q <= 1'b0;
			a_lt_q <= 1'b0;
			b_gt_q <= 1'b0;
			b_lt_q <= 1'b0;
			bis_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (psel && penable && pwrite && paddr[2] == REG_ACCURACY)
				accuracy_q <= pwdata[30:0];

			// Load a finished result when free; drop the response once taken.
			if (st_q == S_DONE && out_free) begin
				out_vld_q <= 1'b1;
				out_kind_q <= res_kind_q;
				out_point_q <= res_point_q;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end

			case (st_q)
				S_IDLE: begin
					if (accept) begin
						f_q <= req.func_value;
						df_q <= req.func_slope;
						if (req.command == CMD_START) begin
							first_q <= req.lower_bound;
							second_q <= req.upper_bound;
							iter_q <= '0;
							phase_q <= PH_FIRST;
							res_kind_q <= K_EVAL;
							res_point_q <= req.lower_bound;
						end else begin
							case (phase_q)
								PH_FIRST: begin
									vfirst_q <= f_in;
									phase_q <= PH_SECOND;
									res_kind_q <= K_EVAL;
									res_point_q <= second_q;
								end
								PH_SECOND: begin
									if ((fl > 0 && f_in > 0) || (fl < 0 && f_in < 0)) begin
										phase_q <= PH_IDLE;
										res_kind_q <= K_NOBRACKET;
										res_point_q <= '0;
									end else if (fl == 0) begin
										phase_q <= PH_IDLE;
										res_kind_q <= K_ROOT;
										res_point_q <= first_q;
									end else if (f_in == 0) begin
										phase_q <= PH_IDLE;
										res_kind_q <= K_ROOT;
										res_point_q <= second_q;
									end else begin
										if (fl < 0) begin
											neg_q <= first_q;
											pos_q <= second_q;
										end else begin
											pos_q <= first_q;
											neg_q <= second_q;
										end
										est_q <= ends_sum[32:1];
										step_q <= ends_mag > 33'sh0_7FFF_FFFF ? MAX32
											: ends_mag[31:0];
										pstep_q <= ends_mag > 33'sh0_7FFF_FFFF ? MAX32
											: ends_mag[31:0];
										iter_q <= '0;
										phase_q <= PH_MID;
										res_kind_q <= K_EVAL;
										res_point_q <= ends_sum[32:1];
									end
								end
								PH_MID: begin
									res_kind_q <= K_EVAL;
								end
								PH_ITER: begin
									// Narrow the bracket at the last estimate.
									if (f_in < 0)
										neg_q <= est_q;
									else
										pos_q <= est_q;
									if (iter_q >= 7'(ITER_LIMIT)) begin
										phase_q <= PH_IDLE;
										res_kind_q <= K_MAXITER;
										res_point_q <= '0;
									end
								end
								default: begin
									res_kind_q <= K_IGNORED;
									res_point_q <= '0;
								end
							endcase
						end
					end
				end
				S_MUL_B: begin
					a_gt_q <= prod_q > fs_x;
					a_lt_q <= prod_q < fs_x;
				end
				S_MUL_C: begin
					b_gt_q <= prod_q > fs_x;
					b_lt_q <= prod_q < fs_x;
				end
				S_DECIDE: begin
					pstep_q <= step_q;
					bis_q <= bisect;
				end
				S_BISECT: step_q <= sat33(bis_dx);
				S_NEWT: begin
					// Apply the quotient sign and saturate.
					if (f_q[31] ^ df_q[31])
						step_q <= (div_q >= 64'h8000_0000) ? MIN32 : 32'(-div_q[31:0]);
					else
						step_q <= (div_q >= 64'h8000_0000) ? MAX32 : div_q[31:0];
				end
				S_FINISH: begin
					est_q <= est_new;
					res_point_q <= est_new;
					if (is_root || step_mag < {1'b0, accuracy_q}) begin
						phase_q <= PH_IDLE;
						res_kind_q <= K_ROOT;
					end else begin
						iter_q <= iter_q + 7'd1;
						phase_q <= PH_ITER;
						res_kind_q <= K_EVAL;
					end
				end
				default: ;
			endcase
		end
	end

	`SNRF_ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, accept, st_q != S_IDLE)
	`SNRF_ASSERT_NOW(a_div_done_in_div, clk, arst_n, div_done, st_q == S_DIV)
	`SNRF_ASSERT_NEXT(a_done_loads_out, clk, arst_n, st_q == S_DONE && out_free, rsp.valid)
	`SNRF_ASSERT_NEXT(a_idle_reply_ignored, clk, arst_n,
		accept && req.command != CMD_START && phase_q == PH_IDLE, res_kind_q == K_IGNORED)

endmodule
`default_nettype wire

// ----- rtl/core/snrf_div.sv -----
// Unsigned 64 by 32 restoring divider, two quotient bits per cycle.
// Does not use snrf_pkg; standalone.
`default_nettype none
module snrf_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             done,
	output logic [63:0]      quotient
);
	logic [32:0] rem_q, rem_d;
	logic [63:0] dq_q, dq_d;
	logic [31:0] dvs_q;
	logic [4:0]  cnt_q;
	logic        busy_q, done_q;

	always_comb begin
		rem_d = rem_q;
		dq_d = dq_q;
		for (int k = 0; k < 2; k++) begin
			rem_d = {rem_d[31:0], dq_d[63]};
			dq_d = {dq_d[62:0], 1'b0};
			if (rem_d >= {1'b0, dvs_q}) begin
				rem_d = rem_d - {1'b0, dvs_q};
				dq_d[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dq_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_d;
			dq_q <= dq_d;
		end
	end

	assign done = done_q;
	assign quotient = dq_q;
endmodule
`default_nettype wire

// ----- verif/safeguarded_newton_root_finder_core_tb.sv -----
// Self-checking testbench of the safeguarded Newton root finder core.
// Drives search commands and evaluator replies, checks every response beat.
// Depends on snrf_pkg, snrf_if.sv and the core RTL.
`default_nettype none

module safeguarded_newton_root_finder_core_tb;
	import snrf_pkg::*;

	localparam int ITERS  = 100;
	localparam int FRAC   = 16;
	localparam int MAX_CYCLES = 600000;

	// Expected response beat.
	typedef struct {
		kind_t       kind;
		logic [31:0] point;
	} answer_t;

	int error_count;

	task automatic report(input string what);
		error_count++;
		$display("MISMATCH at %0t: %s", $realtime, what);
	endtask

	// Scoreboard: a bit-true copy of the search state, plus the answers
	// still owed by the block, oldest first.
	class root_search_board;
		logic [30:0]  accuracy_q16;
		phase_t       search_phase;
		logic signed [31:0] end_a, end_b, f_at_a;
		logic signed [31:0] neg_end, pos_end, guess, dx_now, dx_prev;
		int unsigned  steps_done;
		answer_t      owed[$];

		function new();
			accuracy_q16 = 31'd1;
			search_phase = PH_IDLE;
			end_a = 0; end_b = 0; f_at_a = 0;
			neg_end = 0; pos_end = 0; guess = 0; dx_now = 0; dx_prev = 0;
			steps_done = 0;
		endfunction

		function automatic logic signed [31:0] clamp(input logic signed [65:0] v);
			if (v > 66'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
			if (v < -66'sh8000_0000) return 32'sh8000_0000;
			return v[31:0];
		endfunction

		// Arithmetic shift rounds toward minus infinity.
		function automatic logic signed [65:0] halve(input logic signed [65:0] v);
			return v >>> 1;
		endfunction

		function automatic logic [65:0] absval(input logic signed [65:0] v);
			return v < 0 ? -v : v;
		endfunction

		function automatic void owe(input kind_t k, input logic [31:0] p);
			answer_t a;
			a.kind = k;
			a.point = p;
			owed.push_back(a);
		endfunction

		// Sign of (d*df - fs), exact in wide arithmetic.
		function automatic int guard(input logic signed [65:0] d,
				input logic signed [65:0] df, input logic signed [65:0] fs);
			logic signed [131:0] p;
			p = d * df;
			return (p > fs) ? 1 : (p < fs) ? -1 : 0;
		endfunction

		function automatic void refine(input logic signed [65:0] f,
				input logic signed [65:0] df);
			logic signed [65:0] fs, x, xl, xh, old;
			logic [131:0] lhs, rhs;
			bit bis;
			x = guess; xl = neg_end; xh = pos_end;
			fs = f <<< FRAC;
			bis = (df == 0);
			if (!bis) begin
				lhs = 2 * absval(fs);
				rhs = absval(dx_prev) * absval(df);
				if (guard(x - xh, df, fs) * guard(x - xl, df, fs) >= 0 || lhs > rhs)
					bis = 1;
			end
			dx_prev = dx_now;
			if (bis) begin
				dx_now = clamp(halve(xh - xl));
				guess = clamp(xl + dx_now);
				if (guess == xl) begin
					search_phase = PH_IDLE;
					owe(K_ROOT, guess);
					return;
				end
			end else begin
				old = x;
				dx_now = clamp(fs / df);
				guess = clamp(x - dx_now);
				if (guess == old) begin
					search_phase = PH_IDLE;
					owe(K_ROOT, guess);
					return;
				end
			end
			if (absval(dx_now) < accuracy_q16) begin
				search_phase = PH_IDLE;
				owe(K_ROOT, guess);
				return;
			end
			steps_done = (steps_done + 1) & 7'h7F;
			search_phase = PH_ITER;
			owe(K_EVAL, guess);
		endfunction

		// Note an accepted request beat and predict its response.
		function automatic void note_request(input logic cmd, input logic [31:0] lo,
				input logic [31:0] hi, input logic [31:0] fv, input logic [31:0] fd);
			logic signed [65:0] f, df, fl;
			if (cmd == CMD_START) begin
				end_a = lo; end_b = hi; steps_done = 0;
				search_phase = PH_FIRST;
				owe(K_EVAL, lo);
				return;
			end
			f = $signed(fv); df = $signed(fd);
			case (search_phase)
				PH_FIRST: begin
					f_at_a = fv;
					search_phase = PH_SECOND;
					owe(K_EVAL, end_b);
				end
				PH_SECOND: begin
					fl = f_at_a;
					if ((fl > 0 && f > 0) || (fl < 0 && f < 0)) begin
						search_phase = PH_IDLE;
						owe(K_NOBRACKET, 0);
					end else if (fl == 0) begin
						search_phase = PH_IDLE;
						owe(K_ROOT, end_a);
					end else if (f == 0) begin
						search_phase = PH_IDLE;
						owe(K_ROOT, end_b);
					end else begin
						if (fl < 0) begin
							neg_end = end_a; pos_end = end_b;
						end else begin
							pos_end = end_a; neg_end = end_b;
						end
						guess = halve(66'(end_a) + 66'(end_b));
						dx_now = clamp(absval(66'(end_b) - 66'(end_a)));
						dx_prev = dx_now;
						steps_done = 0;
						search_phase = PH_MID;
						owe(K_EVAL, guess);
					end
				end
				PH_MID: refine(f, df);
				PH_ITER: begin
					if (f < 0) neg_end = guess;
					else pos_end = guess;
					if (steps_done >= ITERS) begin
						search_phase = PH_IDLE;
						owe(K_MAXITER, 0);
					end else begin
						refine(f, df);
					end
				end
				default: owe(K_IGNORED, 0);
			endcase
		endfunction

		// Check a response beat against the oldest owed answer.
		task automatic check_response(input logic [2:0] k, input logic [31:0] p);
			answer_t a;
			if (owed.size() == 0) begin
				report($sformatf("unexpected response kind %0d point %h", k, p));
				return;
			end
			a = owed.pop_front();
			if (k !== a.kind)
				report($sformatf("kind %0d, want %0d", k, a.kind));
			if (p !== a.point)
				report($sformatf("point %h, want %h", p, a.point));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	snrf_req_if req ();
	snrf_rsp_if rsp ();

	safeguarded_newton_root_finder_core #(.ITER_LIMIT(ITERS), .FRAC_BITS(FRAC)) u_dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	root_search_board board = new();

	// Knobs shared by the drivers: idle rate in percent and the hold-off.
	int  idle_pct = 19;
	bit  hold_rsp = 1'b0;
	int  cycle_count;

	initial begin
		req.valid = 1'b0;
		req.command = 1'b0;
		req.lower_bound = '0;
		req.upper_bound = '0;
		req.func_value = '0;
		req.func_slope = '0;
		rsp.ready = 1'b0;
	end

	// Watchdog: end the run if it hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > MAX_CYCLES) begin
			$display("safeguarded_newton_root_finder_core_tb failed");
			$finish;
		end
	end

	// Check every response beat at the rising edge.
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			board.check_response(rsp.kind, rsp.point);
	end

	// Drive response ready at the falling edge; honor the hold-off.
	always @(negedge clk) begin
		if (!arst_n || hold_rsp)
			rsp.ready <= 1'b0;
		else
			rsp.ready <= ($urandom_range(99) >= idle_pct);
	end

	// Write a register through the APB port: setup then access.
	task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= addr; pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		board.accuracy_q16 = data[30:0];
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	// Offer one request beat and hold it until accepted.
	task automatic send_beat(input logic cmd, input logic [31:0] lo, input logic [31:0] hi,
			input logic [31:0] fv, input logic [31:0] fd);
		while ($urandom_range(99) < idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.command <= cmd;
		req.lower_bound <= lo;
		req.upper_bound <= hi;
		req.func_value <= fv;
		req.func_slope <= fd;
		do @(posedge clk); while (!req.ready);
		board.note_request(cmd, lo, hi, fv, fd);
		@(negedge clk);
		req.valid = 1'b0;
	endtask

	task automatic start(input logic [31:0] lo, input logic [31:0] hi);
		send_beat(CMD_START, lo, hi, $urandom, $urandom);
	endtask

	task automatic answer(input logic [31:0] fv, input logic [31:0] fd);
		send_beat(!CMD_START, $urandom, $urandom, fv, fd);
	endtask

	// Drain owed answers, then let any late work settle before a register write.
	task automatic settle();
		while (board.owed.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	// Evaluate a test polynomial f(x) = (x - r) * g at point x, with a slope
	// that is usually right but sometimes corrupted to stress the guard.
	logic signed [31:0] root_x, gain;

	task automatic play_search(input logic signed [31:0] lo, input logic signed [31:0] hi,
			input int max_replies);
		logic signed [63:0] fx;
		logic signed [31:0] fv, fd;
		int n;
		start(lo, hi);
		for (n = 0; n < max_replies; n++) begin
			if (board.search_phase == PH_IDLE && board.owed.size() == 0) break;
			// Wait for the point we are to answer.
			while (board.owed.size() != 0) @(negedge clk);
			if (board.search_phase == PH_IDLE) break;
			fx = ((64'(board.search_phase == PH_FIRST ? lo :
				board.search_phase == PH_SECOND ? hi : board.guess)) - root_x) * gain;
			fv = 32'(fx >>> FRAC);
			case ($urandom_range(9))
				0: fd = 0;
				1: fd = $urandom;
				default: fd = gain;
			endcase
			answer(fv, fd);
		end
	endtask

	initial begin
		int i, k;
		logic signed [31:0] lo, hi;
		cycle_count = 0;
		error_count = 0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: reply while idle, field extremes, endpoint roots, no bracket.
		answer(32'h7FFF_FFFF, 32'h8000_0000);
		answer(32'h8000_0000, 32'h7FFF_FFFF);
		start(32'h8000_0000, 32'h7FFF_FFFF);
		answer(32'h8000_0000, 0);
		answer(32'h7FFF_FFFF, 0);
		answer(32'hFFFF_0000, 0);
		start(32'h7FFF_FFFF, 32'h8000_0000);
		answer(0, 0);
		answer(5, 5);
		start(32'h0001_0000, 32'h0002_0000);
		answer(32'h0000_1000, 1);
		answer(0, 1);
		start(1, 2);
		answer(3, 1);
		answer(7, 1);
		start(-5, 5);
		answer(-1, 1);
		answer(-3, 0);
		start(3, 4);
		answer(1, 1);
		start(0, 0);
		answer(-1, 0);
		answer(1, 0);
		answer(1, 0);

		settle();
		reg_write({REG_ACCURACY, 2'b00}, 32'h7FFF_FFFF);
		root_x = 32'sh0000_8000; gain = 32'sh0002_0000;
		play_search(32'shFFFF_0000, 32'sh0003_0000, 40);
		settle();
		reg_write({REG_ACCURACY, 2'b00}, 32'd0);
		// Zero accuracy, zero slope always: bisection runs until the bracket stops shrinking.
		start(32'h8000_0000, 32'h7FFF_FFFF);
		answer(-1, 0);
		answer(1, 0);
		for (i = 0; i < 110 && board.search_phase != PH_IDLE; i++)
			answer($urandom_range(1) ? -1 : 1, 0);

		// Random part, phases with different accuracy settings.
		for (k = 0; k < 4; k++) begin
			settle();
			case (k)
				0: reg_write({REG_ACCURACY, 2'b00}, 32'd1);
				1: reg_write({REG_ACCURACY, 2'b00}, {17'd0, 15'($urandom)});
				2: reg_write({REG_ACCURACY, 2'b00}, 32'h0000_0100);
				default: reg_write({REG_ACCURACY, 2'b00}, {1'b0, 31'($urandom)});
			endcase
			// Long stretch with no idling at all in the second phase.
			idle_pct = (k == 1) ? 0 : 19;
			for (i = 0; i < 70; i++) begin
				lo = $urandom; hi = $urandom;
				if ($urandom_range(3) != 0) begin
					lo = $signed(lo) >>> $urandom_range(20);
					hi = $signed(hi) >>> $urandom_range(20);
				end
				// Put the root inside the bracket half the time.
				root_x = $urandom_range(1) ? 32'(64'(lo) + ((64'(hi) - 64'(lo)) *
					64'(int'($urandom_range(1000)))) / 64'sd1000) : $urandom;
				gain = $signed(32'($urandom)) >>> $urandom_range(16, 30);
				if (gain == 0) gain = 32'sh0001_0000;
				play_search(lo, hi, $urandom_range(3, 25));
				// Noise: stray replies and raw random beats.
				if ($urandom_range(4) == 0)
					send_beat(1'($urandom_range(1)), $urandom, $urandom, $urandom, $urandom);
			end
			if (k == 2) begin
				// Hold the response side off while requests keep coming.
				hold_rsp = 1'b1;
				fork
					begin
						repeat (300) @(negedge clk);
						hold_rsp = 1'b0;
					end
					for (i = 0; i < 6; i++)
						send_beat(1'($urandom_range(1)), $urandom, $urandom, $urandom,
							$urandom);
				join
			end
		end

		while (board.owed.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (error_count == 0)
			$display("safeguarded_newton_root_finder_core_tb passed");
		else
			$display("safeguarded_newton_root_finder_core_tb failed");
		$finish;
	end

endmodule

`default_nettype wire
